// File: hw/rtl/mlct_pkg.sv
// ----------------------------------------------------------------------------
// mlct_pkg: shared types and constants of the motor link block
// Opcodes, parser phases, drive directions, register indexes and widths.
// ----------------------------------------------------------------------------
package mlct_pkg;

    localparam int OPCODE_W = 3;
    localparam int BYTE_W   = 8;
    localparam int DUTY_W   = 16;
    localparam int DIR_W    = 2;
    localparam int COUNT_W  = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;
    // Speed magnitude runs 0..32768 and needs one bit more than a half range.
    localparam int MAG_W    = 17;
    // The duty is magnitude * period / 32768, a right shift by this amount.
    localparam int MAG_SHIFT = 15;

    localparam logic [15:0] SPEED_MID = 16'h8000;

    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hAA;
    localparam logic [DUTY_W-1:0] PERIOD_RESET = 16'hFFFF;

    typedef enum logic [OPCODE_W-1:0] {
        OP_RX_BYTE  = 3'd0,
        OP_FWD_EDGE = 3'd1,
        OP_BWD_EDGE = 3'd2,
        OP_TICK     = 3'd3,
        OP_OVERRUN  = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_HIGH   = 2'd1,
        PH_LOW    = 2'd2
    } phase_t;

    localparam logic [DIR_W-1:0] DIR_COAST = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FWD   = 2'd1;
    localparam logic [DIR_W-1:0] DIR_REV   = 2'd2;

    localparam logic KIND_DRIVE = 1'b0;
    localparam logic KIND_TELE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEADER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD   = 1'b1;

    // Telemetry beat positions inside one four-byte frame.
    localparam logic [1:0] BEAT_HEADER = 2'd0;
    localparam logic [1:0] BEAT_DIR    = 2'd1;
    localparam logic [1:0] BEAT_HIGH   = 2'd2;
    localparam logic [1:0] BEAT_LOW    = 2'd3;

endpackage

// File: hw/rtl/mlct_duty.sv
// ----------------------------------------------------------------------------
// mlct_duty: PWM compare value from speed magnitude and period
// Scales the magnitude by period/32768 and clamps to period - 1.
// ----------------------------------------------------------------------------
module mlct_duty (
    input  logic [mlct_pkg::MAG_W-1:0]  mag,
    input  logic [mlct_pkg::DUTY_W-1:0] period,
    output logic [mlct_pkg::DUTY_W-1:0] duty
);
    import mlct_pkg::*;

    localparam int PROD_W = MAG_W + DUTY_W;
    localparam int QUOT_W = PROD_W - MAG_SHIFT;

    logic [PROD_W-1:0] prod;
    logic [QUOT_W-1:0] quot;
    logic [DUTY_W-1:0] limit;

    assign prod  = PROD_W'(mag) * PROD_W'(period);
    assign quot  = prod[PROD_W-1:MAG_SHIFT];
    // A period of zero saturates the limit at zero instead of wrapping.
    assign limit = (period == '0) ? '0 : period - DUTY_W'(1);

    always_comb
    begin
        if (quot > QUOT_W'(limit))
        begin
            duty = limit;
        end
        else
        begin
            duty = quot[DUTY_W-1:0];
        end
    end

endmodule

// File: hw/rtl/motor_link_command_and_telemetry_top.sv
// ----------------------------------------------------------------------------
// motor_link_command_and_telemetry_top: link command parser and telemetry
// Parses three-byte speed frames into drive updates, counts encoder edges
// and sends a four-byte telemetry frame on every report tick.
// ----------------------------------------------------------------------------
//
//  Channel    | Handshake            | Payload
//  -----------+----------------------+-----------------------------------------
//  input      | in_valid / in_stall  | opcode, rx_byte
//  result     | out_valid / out_stall| kind, duty, drive_dir, tx_byte, last
//  config     | cfg_we               | cfg_index, cfg_data
//
// A request is accepted when its valid is high and its stall is low. Rx bytes,
// edges and overruns may follow back to back. A request that makes results
// parks in the job register for a drive update or the four bytes of a report
// tick (one byte per cycle unless out_stall holds it) and holds in_stall until
// its last result moves on. A result passes through the job register and the
// result register; under out_stall the job register takes one more request.
// Reset is asynchronous and restores control state and both config registers.
module motor_link_command_and_telemetry_top (
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration write port
    input  logic                           cfg_we,
    input  logic [mlct_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mlct_pkg::CFG_W-1:0]     cfg_data,
    // Input requests
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [mlct_pkg::OPCODE_W-1:0]  opcode,
    input  logic [mlct_pkg::BYTE_W-1:0]    rx_byte,
    // Results
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           kind,
    output logic [mlct_pkg::DUTY_W-1:0]    duty,
    output logic [mlct_pkg::DIR_W-1:0]     drive_dir,
    output logic [mlct_pkg::BYTE_W-1:0]    tx_byte,
    output logic                           last
);
    import mlct_pkg::*;

    // Configuration registers.
    logic [BYTE_W-1:0] header_reg;
    logic [DUTY_W-1:0] period_reg;

    // Parser and counters.
    phase_t             phase_reg, phase_next;
    logic [BYTE_W-1:0]  speed_high_reg;
    logic [COUNT_W-1:0] fwd_reg, fwd_next;
    logic [COUNT_W-1:0] bwd_reg, bwd_next;

    // Job register between the accept side and the result register.
    logic               job_valid_reg, job_valid_next;
    logic               job_tele_reg;
    logic [1:0]         job_beat_reg, job_beat_next;
    logic [MAG_W-1:0]   job_mag_reg;
    logic [DIR_W-1:0]   job_dir_reg;
    logic [BYTE_W-1:0]  job_hdr_reg;
    logic [DIR_W-1:0]   job_tdir_reg;
    logic [COUNT_W-1:0] job_count_reg;

    // Result register.
    logic               out_valid_reg, out_valid_next;
    logic               kind_reg;
    logic [DUTY_W-1:0]  duty_reg;
    logic [DIR_W-1:0]   dir_reg;
    logic [BYTE_W-1:0]  tx_reg;
    logic               last_reg;

    logic              in_accept;
    logic              load_drive;
    logic              load_tele;
    logic              out_load;
    logic              job_done;
    logic [15:0]       speed;
    logic [MAG_W-1:0]  speed_mag;
    logic [DIR_W-1:0]  speed_dir;
    logic [DUTY_W-1:0] job_duty;
    logic [BYTE_W-1:0] tele_byte;

    // ------------------------------------------------------------------
    // Handshake. The job register frees itself in the same cycle that its
    // final result moves on, so a new request may enter right behind it.
    // ------------------------------------------------------------------
    assign out_load  = job_valid_reg && (!out_valid_reg || !out_stall);
    assign job_done  = out_load && (!job_tele_reg || job_beat_reg == BEAT_LOW);
    assign in_stall  = job_valid_reg && !job_done;
    assign in_accept = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // Configuration registers. The user must have writes arrive only while the block is idle (unenforced).
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= HEADER_RESET;
            period_reg <= PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_HEADER: header_reg <= cfg_data[BYTE_W-1:0];
                REG_PWM_PERIOD:   period_reg <= cfg_data[DUTY_W-1:0];
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Frame parser: next phase. An overrun always drops back to waiting for
    // a header; the unused phase code behaves like the header phase.
    // ------------------------------------------------------------------
    always_comb
    begin
        phase_next = phase_reg;
        if (in_accept)
        begin
            if (opcode == OP_OVERRUN)
            begin
                phase_next = PH_HEADER;
            end
            else if (opcode == OP_RX_BYTE)
            begin
                unique case (phase_reg)
                    PH_HIGH: phase_next = PH_LOW;
                    PH_LOW:  phase_next = PH_HEADER;
                    default: phase_next = (rx_byte == header_reg) ? PH_HIGH : PH_HEADER;
                endcase
            end
        end
    end

    // Parser outputs: which request loads a job.
    always_comb
    begin
        load_drive = 1'b0;
        load_tele  = 1'b0;
        if (in_accept)
        begin
            load_drive = (opcode == OP_RX_BYTE) && (phase_reg == PH_LOW);
            load_tele  = (opcode == OP_TICK);
        end
    end

    // Edge counters wrap at 16 bits and clear on a report tick.
    always_comb
    begin
        fwd_next = fwd_reg;
        bwd_next = bwd_reg;
        if (in_accept)
        begin
            unique case (opcode)
                OP_FWD_EDGE: fwd_next = fwd_reg + COUNT_W'(1);
                OP_BWD_EDGE: bwd_next = bwd_reg + COUNT_W'(1);
                OP_TICK:
                begin
                    fwd_next = '0;
                    bwd_next = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            fwd_reg   <= '0;
            bwd_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            fwd_reg   <= fwd_next;
            bwd_reg   <= bwd_next;
        end
    end

    // The high speed byte is always written before the low byte reads it.
    always_ff @(posedge clk)
    begin
        if (in_accept && opcode == OP_RX_BYTE && phase_reg == PH_HIGH)
        begin
            speed_high_reg <= rx_byte;
        end
    end

    // ------------------------------------------------------------------
    // Speed to direction and magnitude. The magnitude is one bit wider than
    // the speed so that full reverse (speed zero) gives exactly 32768.
    // ------------------------------------------------------------------
    assign speed = {speed_high_reg, rx_byte};

    always_comb
    begin
        if (speed[15])
        begin
            speed_mag = MAG_W'(speed[14:0]);
            speed_dir = (speed == SPEED_MID) ? DIR_COAST : DIR_FWD;
        end
        else
        begin
            speed_mag = MAG_W'(SPEED_MID) - MAG_W'(speed);
            speed_dir = DIR_REV;
        end
    end

    // ------------------------------------------------------------------
    // Job register. A tick captures the counters as they stand before the
    // clear, so later edges land in the fresh counts.
    // ------------------------------------------------------------------
    always_comb
    begin
        job_valid_next = job_valid_reg;
        job_beat_next  = job_beat_reg;
        if (load_drive || load_tele)
        begin
            job_valid_next = 1'b1;
            job_beat_next  = BEAT_HEADER;
        end
        else if (job_done)
        begin
            job_valid_next = 1'b0;
        end
        else if (out_load)
        begin
            job_beat_next = job_beat_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            job_beat_reg  <= BEAT_HEADER;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            job_beat_reg  <= job_beat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_drive || load_tele)
        begin
            job_tele_reg <= load_tele;
            job_mag_reg  <= speed_mag;
            job_dir_reg  <= speed_dir;
            job_hdr_reg  <= header_reg;
            if (fwd_reg >= bwd_reg)
            begin
                job_tdir_reg  <= DIR_FWD;
                job_count_reg <= fwd_reg;
            end
            else
            begin
                job_tdir_reg  <= DIR_REV;
                job_count_reg <= bwd_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result formation: duty scaling for drives, byte select for telemetry.
    // ------------------------------------------------------------------
    mlct_duty u_duty (
        .mag    (job_mag_reg),
        .period (period_reg),
        .duty   (job_duty)
    );

    always_comb
    begin
        unique case (job_beat_reg)
            BEAT_HEADER: tele_byte = job_hdr_reg;
            BEAT_DIR:    tele_byte = BYTE_W'(job_tdir_reg);
            BEAT_HIGH:   tele_byte = job_count_reg[COUNT_W-1:BYTE_W];
            BEAT_LOW:    tele_byte = job_count_reg[BYTE_W-1:0];
            default:     tele_byte = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (job_tele_reg)
            begin
                kind_reg <= KIND_TELE;
                duty_reg <= '0;
                dir_reg  <= DIR_COAST;
                tx_reg   <= tele_byte;
                last_reg <= (job_beat_reg == BEAT_LOW);
            end
            else
            begin
                kind_reg <= KIND_DRIVE;
                duty_reg <= job_duty;
                dir_reg  <= job_dir_reg;
                tx_reg   <= '0;
                last_reg <= 1'b1;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign duty      = duty_reg;
    assign drive_dir = dir_reg;
    assign tx_byte   = tx_reg;
    assign last      = last_reg;

`ifndef ASSERT_OFF
    // Only telemetry jobs ever advance past their first beat.
    a_beat_tele: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg && job_beat_reg != BEAT_HEADER |-> job_tele_reg)
        else $error("job beat advanced on a drive update");

    // Input is stalled only while a job is pending.
    a_stall_job: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> job_valid_reg)
        else $error("input stalled with no pending job");

    // A drive update is always a single, final result with no byte.
    a_drive_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_DRIVE |-> last && tx_byte == '0)
        else $error("drive update not marked last");

    // Coasting drives a zero duty.
    a_coast_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && drive_dir == DIR_COAST |-> duty == '0)
        else $error("nonzero duty while coasting");
`endif

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for motor_link_command_and_telemetry_top
// Feeds link bytes, encoder edges, report ticks and overruns through a
// valid/stall request channel and checks every drive update and telemetry
// byte against a cycle-free prediction of the parser and edge counters.
// ----------------------------------------------------------------------------
module tb;
    import mlct_pkg::*;

    // Opcodes past the defined set. The block must ignore them.
    localparam logic [OPCODE_W-1:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_UNUSED_MID   = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_UNUSED_LAST  = 3'd7;

    localparam int PHASE_ITEMS  = 56;
    localparam int NUM_PHASES   = 5;
    localparam int LONG_HOLD    = 80;
    localparam int SETTLE_LEN   = 10;
    localparam int MAX_REPORTS  = 40;

    typedef struct packed {
        logic              kind;
        logic [DUTY_W-1:0] duty;
        logic [DIR_W-1:0]  dir;
        logic [BYTE_W-1:0] tx;
        logic              last;
    } link_result_t;

    typedef struct {
        logic [OPCODE_W-1:0] op;
        logic [BYTE_W-1:0]   data;
        int unsigned         gap;
    } link_req_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_FRAME_HEADER;
    logic [CFG_W-1:0]      cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [OPCODE_W-1:0]   opcode    = OP_RX_BYTE;
    logic [BYTE_W-1:0]     rx_byte   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  kind;
    logic [DUTY_W-1:0]     duty;
    logic [DIR_W-1:0]      drive_dir;
    logic [BYTE_W-1:0]     tx_byte;
    logic                  last;

    motor_link_command_and_telemetry_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .duty      (duty),
        .drive_dir (drive_dir),
        .tx_byte   (tx_byte),
        .last      (last)
    );

    // 20 time unit clock, starting low.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction state: our own copy of the parser, the edge counters and the
    // two configuration registers. It advances once per accepted request.
    // ------------------------------------------------------------------------
    phase_t             rx_phase   = PH_HEADER;
    logic [BYTE_W-1:0]  spd_hi     = '0;
    logic [COUNT_W-1:0] fwd_count  = '0;
    logic [COUNT_W-1:0] bwd_count  = '0;
    logic [BYTE_W-1:0]  hdr_reg    = HEADER_RESET;
    logic [DUTY_W-1:0]  period_reg = PERIOD_RESET;

    // Drive updates and telemetry bytes that the block still owes us, oldest
    // first, and the requests still waiting to be offered.
    link_result_t due_results[$];
    link_req_t    req_queue[$];

    int reqs_queued    = 0;
    int reqs_accepted  = 0;
    int useful_reqs    = 0;
    int frames_seen    = 0;
    int ticks_seen     = 0;
    int results_checked = 0;
    int settings_used  = 1;
    int errors         = 0;
    bit no_gap         = 1'b1;

    // Advances the predicted parser and counters by one accepted request and
    // queues whatever drive update or telemetry frame it produces.
    task automatic link_step(input logic [OPCODE_W-1:0] op, input logic [BYTE_W-1:0] data);
        link_result_t        r;
        logic [15:0]         speed;
        logic [MAG_W-1:0]    mag;
        logic [32:0]         scaled;
        logic [DUTY_W-1:0]   limit;
        logic [COUNT_W-1:0]  count;
        logic [BYTE_W-1:0]   dir_byte;
        begin
            r = '0;
            case (op)
                OP_RX_BYTE:
                begin
                    if (rx_phase == PH_HIGH)
                    begin
                        spd_hi   = data;
                        rx_phase = PH_LOW;
                    end
                    else if (rx_phase == PH_LOW)
                    begin
                        rx_phase = PH_HEADER;
                        speed    = {spd_hi, data};
                        r.kind   = KIND_DRIVE;
                        r.last   = 1'b1;
                        if (speed == SPEED_MID)
                        begin
                            r.dir  = DIR_COAST;
                            r.duty = '0;
                        end
                        else
                        begin
                            // Magnitude runs 1..32768; the full reverse value
                            // must come through without wrapping.
                            if (speed > SPEED_MID)
                            begin
                                r.dir = DIR_FWD;
                                mag   = speed - SPEED_MID;
                            end
                            else
                            begin
                                r.dir = DIR_REV;
                                mag   = SPEED_MID - speed;
                            end
                            scaled = (mag * period_reg) >> MAG_SHIFT;
                            limit  = (period_reg == '0) ? '0 : period_reg - 1'b1;
                            r.duty = (scaled > limit) ? limit : scaled[DUTY_W-1:0];
                        end
                        due_results.push_back(r);
                        frames_seen++;
                    end
                    else
                    begin
                        rx_phase = (data == hdr_reg) ? PH_HIGH : PH_HEADER;
                    end
                end
                OP_FWD_EDGE: fwd_count = fwd_count + 1'b1;
                OP_BWD_EDGE: bwd_count = bwd_count + 1'b1;
                OP_TICK:
                begin
                    if (fwd_count >= bwd_count)
                    begin
                        dir_byte = BYTE_W'(DIR_FWD);
                        count    = fwd_count;
                    end
                    else
                    begin
                        dir_byte = BYTE_W'(DIR_REV);
                        count    = bwd_count;
                    end
                    fwd_count = '0;
                    bwd_count = '0;
                    r.kind = KIND_TELE;
                    r.tx   = hdr_reg;
                    due_results.push_back(r);
                    r.tx   = dir_byte;
                    due_results.push_back(r);
                    r.tx   = count[15:8];
                    due_results.push_back(r);
                    r.tx   = count[7:0];
                    r.last = 1'b1;
                    due_results.push_back(r);
                    ticks_seen++;
                end
                OP_OVERRUN: rx_phase = PH_HEADER;
                default:
                begin
                    // Undefined opcodes leave every piece of state alone.
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver. Each queued request carries the number of idle cycles to leave
    // in front of it. A request stays on the bus, unchanged, until accepted;
    // a zero gap keeps in_valid high across consecutive requests.
    // ------------------------------------------------------------------------
    int unsigned gap_count = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            opcode    <= OP_RX_BYTE;
            rx_byte   <= '0;
            gap_count <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                link_step(opcode, rx_byte);
                reqs_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (req_queue.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else if (gap_count < req_queue[0].gap)
                begin
                    in_valid  <= 1'b0;
                    gap_count <= gap_count + 1;
                end
                else
                begin
                    in_valid  <= 1'b1;
                    opcode    <= req_queue[0].op;
                    rx_byte   <= req_queue[0].data;
                    gap_count <= 0;
                    void'(req_queue.pop_front());
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Checks every accepted result against the oldest prediction and
    // then draws how long to stall before taking the next one. Twice in the
    // run it holds off for a long stretch so that the job and result
    // registers fill and the block has to stall its input side.
    // ------------------------------------------------------------------------
    int           stall_left = 0;
    int           hold;
    bit           quiet_rx   = 1'b0;
    link_result_t got;
    link_result_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            hold = stall_left;
            if (out_valid && !out_stall)
            begin
                got = '{kind, duty, drive_dir, tx_byte, last};
                if (due_results.size() == 0)
                begin
                    if (errors < MAX_REPORTS)
                        $display("%0t: unexpected result kind=%0d duty=%0d dir=%0d tx=%02h last=%0d",
                                 $time, got.kind, got.duty, got.dir, got.tx, got.last);
                    errors++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got !== want)
                    begin
                        if (errors < MAX_REPORTS)
                        begin
                            $display("%0t: expected kind=%0d duty=%0d dir=%0d tx=%02h last=%0d",
                                     $time, want.kind, want.duty, want.dir, want.tx, want.last);
                            $display("%0t: actual   kind=%0d duty=%0d dir=%0d tx=%02h last=%0d",
                                     $time, got.kind, got.duty, got.dir, got.tx, got.last);
                        end
                        errors++;
                    end
                end
                results_checked++;
                if (results_checked % 16 == 0)
                    quiet_rx = ($urandom_range(0, 2) == 0);
                if (results_checked == 30 || results_checked == 80)
                    hold = LONG_HOLD;
                else if (quiet_rx || $urandom_range(0, 3) == 0)
                    hold = 0;
                else
                    hold = $urandom_range(0, 5);
            end
            out_stall  <= (hold != 0);
            stall_left <= (hold != 0) ? hold - 1 : 0;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic push_req(input logic [OPCODE_W-1:0] op, input logic [BYTE_W-1:0] data);
        link_req_t q;
        begin
            q.op   = op;
            q.data = data;
            q.gap  = no_gap ? 0 : $urandom_range(0, 5);
            req_queue.push_back(q);
            reqs_queued++;
            if (op <= OP_OVERRUN)
                useful_reqs++;
        end
    endtask

    // Sometimes slips an encoder edge or an undefined opcode between the
    // bytes of a frame; neither may disturb the parser.
    task automatic maybe_interleave();
        int pick;
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                push_req(OP_FWD_EDGE, BYTE_W'($urandom));
            else if (pick == 1)
                push_req(OP_BWD_EDGE, BYTE_W'($urandom));
            else if (pick == 2)
                push_req(3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)), BYTE_W'($urandom));
        end
    endtask

    // Waits until every request has been accepted and every prediction has
    // been met, then idles on for work with no result.
    task automatic wait_quiet();
        begin
            @(negedge clk);
            while (reqs_accepted != reqs_queued || due_results.size() != 0)
                @(negedge clk);
            repeat (8) @(negedge clk);
        end
    endtask

    // Register writes happen only while the block is idle, so the predicted
    // copy can be updated at the same moment.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        begin
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            if (idx == REG_FRAME_HEADER)
                hdr_reg = val[BYTE_W-1:0];
            else
                period_reg = val;
            @(posedge clk);
            cfg_we <= 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        logic [15:0]        speed;
        logic [15:0]        special_speed [5];
        logic [BYTE_W-1:0]  hdr_val;
        logic [DUTY_W-1:0]  per_val;
        logic [CFG_W-1:0]   upper;
        int                 start;
        int                 pick;
        int                 run_len;
        int                 fwd_bias;

        special_speed[0] = SPEED_MID;
        special_speed[1] = 16'h0000;
        special_speed[2] = 16'hFFFF;
        special_speed[3] = SPEED_MID + 1'b1;
        special_speed[4] = SPEED_MID - 1'b1;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, on the reset register values. Coast, the largest
        // forward speed, the full reverse magnitude (which must clamp to
        // period - 1), the smallest reverse step.
        no_gap = 1'b1;
        push_req(OP_RX_BYTE, HEADER_RESET);
        push_req(OP_RX_BYTE, SPEED_MID[15:8]);
        push_req(OP_RX_BYTE, SPEED_MID[7:0]);
        push_req(OP_RX_BYTE, HEADER_RESET);
        push_req(OP_RX_BYTE, 8'hFF);
        push_req(OP_RX_BYTE, 8'hFF);
        push_req(OP_RX_BYTE, HEADER_RESET);
        push_req(OP_RX_BYTE, 8'h00);
        push_req(OP_RX_BYTE, 8'h00);
        push_req(OP_RX_BYTE, HEADER_RESET);
        push_req(OP_RX_BYTE, 8'h7F);
        push_req(OP_RX_BYTE, 8'hFF);
        // An overrun in mid-frame drops the frame; the next byte is no header.
        no_gap = 1'b0;
        push_req(OP_RX_BYTE, HEADER_RESET);
        push_req(OP_RX_BYTE, 8'h12);
        push_req(OP_OVERRUN, 8'h00);
        push_req(OP_RX_BYTE, 8'h34);
        // Forward dominant, then backward dominant, then equal (zero) counts.
        push_req(OP_FWD_EDGE, 8'h00);
        push_req(OP_FWD_EDGE, 8'hFF);
        push_req(OP_BWD_EDGE, 8'h00);
        push_req(OP_TICK, 8'h00);
        push_req(OP_BWD_EDGE, 8'h00);
        push_req(OP_TICK, 8'h00);
        push_req(OP_TICK, 8'h00);
        // Undefined opcodes and an edge inside a frame leave it intact.
        push_req(OP_RX_BYTE, HEADER_RESET);
        push_req(OP_UNUSED_FIRST, 8'h00);
        push_req(OP_RX_BYTE, SPEED_MID[15:8]);
        push_req(OP_UNUSED_MID, 8'hFF);
        push_req(OP_FWD_EDGE, 8'h00);
        push_req(OP_UNUSED_LAST, 8'hFF);
        push_req(OP_RX_BYTE, 8'h01);
        wait_quiet();

        // Random part: several register settings, the extremes among them.
        // Most traffic is well-formed frames with random speeds, mixed with
        // edge runs, ticks, broken frames, noise bytes and undefined opcodes.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_quiet();
            case (ph)
                0:       begin hdr_val = 8'h00; per_val = 16'd2;     end
                1:       begin hdr_val = 8'hFF; per_val = 16'hFFFF;  end
                2:       begin hdr_val = BYTE_W'($urandom); per_val = 16'd3; end
                3:       begin hdr_val = HEADER_RESET;
                               per_val = DUTY_W'($urandom_range(2, 65535)); end
                default: begin hdr_val = BYTE_W'($urandom);
                               per_val = DUTY_W'($urandom_range(2, 65535)); end
            endcase
            // Bits above the header width are don't-care and get random values.
            upper = CFG_W'($urandom);
            write_reg(REG_FRAME_HEADER, {upper[CFG_W-1:BYTE_W], hdr_val});
            write_reg(REG_PWM_PERIOD, per_val);
            settings_used++;

            start = useful_reqs;
            while (useful_reqs - start < PHASE_ITEMS)
            begin
                pick   = $urandom_range(0, 99);
                no_gap = ($urandom_range(0, 3) == 0);
                if (pick < 50)
                begin
                    if ($urandom_range(0, 4) == 0)
                        speed = special_speed[$urandom_range(0, 4)];
                    else
                        speed = 16'($urandom);
                    push_req(OP_RX_BYTE, hdr_val);
                    maybe_interleave();
                    push_req(OP_RX_BYTE, speed[15:8]);
                    maybe_interleave();
                    push_req(OP_RX_BYTE, speed[7:0]);
                end
                else if (pick < 65)
                begin
                    // Edge runs lean one way or the other; an occasional long
                    // run reaches into the count high byte.
                    run_len  = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                                            : $urandom_range(1, 24);
                    fwd_bias = $urandom_range(0, 1) ? 3 : 1;
                    for (int i = 0; i < run_len; i++)
                        push_req(($urandom_range(0, 3) < fwd_bias) ? OP_FWD_EDGE : OP_BWD_EDGE,
                                 BYTE_W'($urandom));
                end
                else if (pick < 77)
                begin
                    push_req(OP_TICK, BYTE_W'($urandom));
                end
                else if (pick < 89)
                begin
                    push_req(OP_RX_BYTE, hdr_val);
                    if ($urandom_range(0, 1))
                        push_req(OP_RX_BYTE, BYTE_W'($urandom));
                    push_req(OP_OVERRUN, BYTE_W'($urandom));
                    if ($urandom_range(0, 1))
                        push_req(OP_RX_BYTE, BYTE_W'($urandom));
                end
                else if (pick < 96)
                begin
                    push_req(OP_RX_BYTE, BYTE_W'($urandom));
                end
                else
                begin
                    push_req(3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)),
                             BYTE_W'($urandom));
                end
            end
        end

        wait_quiet();
        repeat (SETTLE_LEN) @(posedge clk);
        if (due_results.size() != 0)
        begin
            $display("%0t: %0d predicted results never arrived", $time, due_results.size());
            errors++;
        end

        $display("Run covered %0d requests: %0d drive frames and %0d report ticks,",
                 reqs_accepted, frames_seen, ticks_seen);
        $display("%0d results checked across %0d register settings, %0d errors.",
                 results_checked, settings_used, errors);
        if (errors == 0)
            $display("motor_link_command_and_telemetry_top verification clean");
        else
            $display("motor_link_command_and_telemetry_top verification failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #10000000;
        $display("%0t: timeout", $time);
        $display("motor_link_command_and_telemetry_top verification failed");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/mlct_pkg.sv
hw/rtl/mlct_duty.sv
hw/rtl/motor_link_command_and_telemetry_top.sv
tb/tb.sv
